// ===== hw/rtl/jcbm_pkg.sv =====
// Shared types and constants of the journaled copy-on-write block mapper.
// Command, status, journal phase and sequencer state codes; field widths.
// No dependencies.
package jcbm_pkg;

	localparam int IdW = 16;
	localparam int LenW = 8;
	localparam int BlkOutW = 7;
	localparam int TxnW = 32;
	localparam int StatusW = 3;
	localparam int PhaseW = 3;
	localparam int CmdW = 2;
	localparam int MapWordBits = 16;
	localparam int MapBitW = 4;

	typedef enum logic [CmdW-1:0] {
		CMD_CREATE = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ = 2'd2,
		CMD_REPAIR = 2'd3
	} cmd_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK = 3'd0,
		ST_NO_BLOCK = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_NOTHING = 3'd4
	} status_t;

	typedef enum logic [PhaseW-1:0] {
		PH_EMPTY = 3'd0,
		PH_STARTED = 3'd1,
		PH_DATA_WRITTEN = 3'd2,
		PH_METADATA_UPDATED = 3'd3,
		PH_COMMITTED = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FIND,
		S_ALLOC,
		S_REL_RD,
		S_REL_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic found;
		logic [MapBitW-1:0] pos;
	} free_t;

endpackage

// ===== hw/rtl/jcbm_ifs.sv =====
// Valid/ready channel interfaces of the block mapper: command and response.
// Depends on jcbm_pkg for field widths.
interface jcbm_req_if;
	logic valid;
	logic ready;
	logic [jcbm_pkg::CmdW-1:0] command;
	logic [jcbm_pkg::IdW-1:0] file_id;
	logic [jcbm_pkg::LenW-1:0] length;
	logic abort_before_commit;

	modport source(output valid, command, file_id, length, abort_before_commit,
		input ready);
	modport sink(input valid, command, file_id, length, abort_before_commit,
		output ready);
endinterface

interface jcbm_rsp_if;
	logic valid;
	logic ready;
	logic [jcbm_pkg::StatusW-1:0] status;
	logic [jcbm_pkg::BlkOutW-1:0] block_index;
	logic [jcbm_pkg::LenW-1:0] file_length;
	logic [jcbm_pkg::PhaseW-1:0] journal_state;
	logic [jcbm_pkg::TxnW-1:0] transaction_id;

	modport source(output valid, status, block_index, file_length, journal_state,
		transaction_id, input ready);
	modport sink(input valid, status, block_index, file_length, journal_state,
		transaction_id, output ready);
endinterface

// ===== hw/rtl/jcbm_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the file table and the block-in-use map. No dependencies.
module jcbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/jcbm_find_free.sv =====
// Lowest free bit of one block-map word, restricted to existing blocks.
// Depends on jcbm_pkg (free_t, MapWordBits).
module jcbm_find_free (
	input logic [jcbm_pkg::MapWordBits-1:0] word,
	input logic [jcbm_pkg::MapWordBits-1:0] mask,
	output jcbm_pkg::free_t free
);

	logic [jcbm_pkg::MapWordBits-1:0] avail;

	assign avail = ~word & mask;

	always_comb begin
		free.found = |avail;
		free.pos = '0;
		for (int i = jcbm_pkg::MapWordBits - 1; i >= 0; i--) begin
			if (avail[i]) begin
				free.pos = jcbm_pkg::MapBitW'(i);
			end
		end
	end

endmodule

// ===== hw/rtl/journaled_cow_block_mapper_unit.sv =====
// Top level of the journaled copy-on-write block mapper: sequencer, journal,
// file table RAM and block-map RAM. Depends on jcbm_pkg, jcbm_ifs, jcbm_ram,
// jcbm_find_free.
//
// Usage: one command transaction on req yields exactly one response on rsp.
// Channels are valid/ready; a transaction moves when both are high.
// req.ready is high only while the sequencer is idle; one command is worked
// on at a time. The response sits in an output register, so the next command
// is taken while an earlier response still waits on a stalled receiver; the
// sequencer holds its finished result until that register is free.
// Latency, from the accepting edge to rsp.valid, with E table entries compared
// and W 16-bit map words scanned (W <= ceil(NUM_BLOCKS/16), 8 at the defaults):
//   read 3+E, create 3+W, repair 4, safe write 6+E+W with commit, 4+E+W aborted.
//   Table full and nothing to repair take 2; a missed id takes 4 plus the entry
//   count (3 on an empty table); no free block takes one cycle more than a full
//   map scan. The scans of the two one-port-read RAMs, one entry or word per
//   cycle, set these figures; the next command is taken when rsp.valid rises.
// Reset: the block map is zeroed by a pass of ceil(NUM_BLOCKS/16) cycles
// during which req.ready stays low; the file table needs no clearing.
module journaled_cow_block_mapper_unit #(
	parameter int NUM_BLOCKS = 128,
	parameter int MAX_FILES = 64
) (
	input logic clk,
	input logic arst_n,
	jcbm_req_if.sink req,
	jcbm_rsp_if.source rsp
);

	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int NW = (NUM_BLOCKS + jcbm_pkg::MapWordBits - 1) / jcbm_pkg::MapWordBits;
	localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
	localparam int WCW = $clog2(NW + 1);
	localparam int NBFW = WAW + jcbm_pkg::MapBitW;
	localparam int LastBits = NUM_BLOCKS - jcbm_pkg::MapWordBits * (NW - 1);
	localparam logic [jcbm_pkg::MapWordBits-1:0] LastMask =
		jcbm_pkg::MapWordBits'((64'd1 << LastBits) - 64'd1);
	localparam int TAW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
	localparam int CW = $clog2(MAX_FILES + 1);
	localparam int TW = jcbm_pkg::IdW + BW + jcbm_pkg::LenW;
	localparam int BXW = (BW > jcbm_pkg::BlkOutW) ? BW : jcbm_pkg::BlkOutW;

	jcbm_pkg::state_t state_q, state_d;
	jcbm_pkg::cmd_t cmd_q;
	jcbm_pkg::phase_t jphase_q;
	jcbm_pkg::status_t res_status_q;
	jcbm_pkg::free_t free;

	logic [jcbm_pkg::IdW-1:0] id_q;
	logic [jcbm_pkg::LenW-1:0] len_q;
	logic abort_q;
	logic [CW-1:0] tidx_q;
	logic [WCW-1:0] widx_q;
	logic tpend_s1, mpend_s1;
	logic [TAW-1:0] tidx_s1, slot_q;
	logic [WAW-1:0] widx_s1;
	logic [BW-1:0] old_q, jnew_q, res_blk_q;
	logic [CW-1:0] cnt_q;
	logic [jcbm_pkg::TxnW-1:0] jtxn_q, ntxn_q;
	logic [jcbm_pkg::LenW-1:0] res_len_q;

	logic ovld_q;
	logic [jcbm_pkg::StatusW-1:0] ostatus_q;
	logic [jcbm_pkg::BlkOutW-1:0] oblk_q;
	logic [jcbm_pkg::LenW-1:0] olen_q;
	logic [jcbm_pkg::PhaseW-1:0] ophase_q;
	logic [jcbm_pkg::TxnW-1:0] otxn_q;

	logic accept, load;
	logic tre, twe, mre, mwe;
	logic [TAW-1:0] traddr, twaddr;
	logic [TW-1:0] twdata, trdata;
	logic [WAW-1:0] mraddr, mwaddr;
	logic [jcbm_pkg::MapWordBits-1:0] mwdata, mrdata, vmask;
	logic [jcbm_pkg::IdW-1:0] t_id;
	logic [BW-1:0] t_blk, nb, rel_blk;
	logic [jcbm_pkg::LenW-1:0] t_len;
	logic [NBFW-1:0] nb_full, rel_full;
	logic [WAW-1:0] rel_word;
	logic tmore, thit, tmiss, mmore, mfound, mmiss, commit, repair_ok;
	logic [BXW-1:0] blk_x;

	assign accept = req.valid && req.ready;
	assign load = (state_q == jcbm_pkg::S_DONE) && (!ovld_q || rsp.ready);

	assign t_id = trdata[TW-1 -: jcbm_pkg::IdW];
	assign t_blk = trdata[jcbm_pkg::LenW +: BW];
	assign t_len = trdata[jcbm_pkg::LenW-1:0];

	assign tmore = tidx_q < cnt_q;
	assign thit = (state_q == jcbm_pkg::S_FIND) && tpend_s1 && (t_id == id_q);
	assign tmiss = (state_q == jcbm_pkg::S_FIND) && !tpend_s1 && !tmore;

	assign vmask = (widx_s1 == WAW'(NW - 1)) ? LastMask : '1;
	assign mmore = widx_q < WCW'(NW);
	assign mfound = (state_q == jcbm_pkg::S_ALLOC) && mpend_s1 && free.found;
	assign mmiss = (state_q == jcbm_pkg::S_ALLOC) && !mpend_s1 && !mmore;
	assign nb_full = {widx_s1, free.pos};
	assign nb = nb_full[BW-1:0];
	assign commit = (cmd_q == jcbm_pkg::CMD_WRITE) && !abort_q;

	assign rel_blk = (cmd_q == jcbm_pkg::CMD_REPAIR) ? jnew_q : old_q;
	assign rel_full = NBFW'(rel_blk);
	assign rel_word = rel_full[NBFW-1:jcbm_pkg::MapBitW];
	assign repair_ok = (jphase_q != jcbm_pkg::PH_COMMITTED) && (jphase_q != jcbm_pkg::PH_EMPTY);
	assign blk_x = BXW'(res_blk_q);

	jcbm_find_free u_find_free (
		.word(mrdata),
		.mask(vmask),
		.free(free)
	);

	jcbm_ram #(.WIDTH(TW), .DEPTH(MAX_FILES)) u_table (
		.clk(clk),
		.we(twe),
		.waddr(twaddr),
		.wdata(twdata),
		.re(tre),
		.raddr(traddr),
		.rdata(trdata)
	);

	jcbm_ram #(.WIDTH(jcbm_pkg::MapWordBits), .DEPTH(NW)) u_map (
		.clk(clk),
		.we(mwe),
		.waddr(mwaddr),
		.wdata(mwdata),
		.re(mre),
		.raddr(mraddr),
		.rdata(mrdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			jcbm_pkg::S_CLEAR: begin
				if (widx_q == WCW'(NW - 1)) state_d = jcbm_pkg::S_IDLE;
			end
			jcbm_pkg::S_IDLE: begin
				if (req.valid) begin
					case (jcbm_pkg::cmd_t'(req.command))
						jcbm_pkg::CMD_CREATE: begin
							state_d = (cnt_q >= CW'(MAX_FILES)) ? jcbm_pkg::S_DONE
								: jcbm_pkg::S_ALLOC;
						end
						jcbm_pkg::CMD_WRITE, jcbm_pkg::CMD_READ: begin
							state_d = jcbm_pkg::S_FIND;
						end
						default: begin
							state_d = repair_ok ? jcbm_pkg::S_REL_RD : jcbm_pkg::S_DONE;
						end
					endcase
				end
			end
			jcbm_pkg::S_FIND: begin
				if (thit) begin
					state_d = (cmd_q == jcbm_pkg::CMD_READ) ? jcbm_pkg::S_DONE
						: jcbm_pkg::S_ALLOC;
				end else if (tmiss) begin
					state_d = jcbm_pkg::S_DONE;
				end
			end
			jcbm_pkg::S_ALLOC: begin
				if (mfound) begin
					state_d = commit ? jcbm_pkg::S_REL_RD : jcbm_pkg::S_DONE;
				end else if (mmiss) begin
					state_d = jcbm_pkg::S_DONE;
				end
			end
			jcbm_pkg::S_REL_RD: state_d = jcbm_pkg::S_REL_WR;
			jcbm_pkg::S_REL_WR: state_d = jcbm_pkg::S_DONE;
			jcbm_pkg::S_DONE: begin
				if (load) state_d = jcbm_pkg::S_IDLE;
			end
			default: state_d = jcbm_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		tre = 1'b0;
		twe = 1'b0;
		mre = 1'b0;
		mwe = 1'b0;
		traddr = tidx_q[TAW-1:0];
		twaddr = slot_q;
		twdata = {id_q, nb, len_q};
		mraddr = rel_word;
		mwaddr = rel_word;
		mwdata = mrdata & ~(jcbm_pkg::MapWordBits'(1) << rel_full[jcbm_pkg::MapBitW-1:0]);
		case (state_q)
			jcbm_pkg::S_CLEAR: begin
				mwe = 1'b1;
				mwaddr = widx_q[WAW-1:0];
				mwdata = '0;
			end
			jcbm_pkg::S_IDLE: req.ready = 1'b1;
			jcbm_pkg::S_FIND: tre = tmore && !thit;
			jcbm_pkg::S_ALLOC: begin
				mre = mmore && !mfound;
				mraddr = widx_q[WAW-1:0];
				mwe = mfound;
				mwaddr = widx_s1;
				mwdata = mrdata | (jcbm_pkg::MapWordBits'(1) << free.pos);
				twe = mfound && (commit || (cmd_q == jcbm_pkg::CMD_CREATE));
				twaddr = (cmd_q == jcbm_pkg::CMD_CREATE) ? cnt_q[TAW-1:0] : slot_q;
			end
			jcbm_pkg::S_REL_RD: mre = 1'b1;
			jcbm_pkg::S_REL_WR: mwe = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jcbm_pkg::S_CLEAR;
			widx_q <= '0;
			tidx_q <= '0;
			tpend_s1 <= 1'b0;
			mpend_s1 <= 1'b0;
			cnt_q <= '0;
			jtxn_q <= '0;
			jnew_q <= '0;
			jphase_q <= jcbm_pkg::PH_EMPTY;
			ntxn_q <= jcbm_pkg::TxnW'(1);
			ovld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tpend_s1 <= tre;
			mpend_s1 <= mre && (state_q == jcbm_pkg::S_ALLOC);
			if (state_q == jcbm_pkg::S_CLEAR) begin
				widx_q <= widx_q + WCW'(1);
			end else if (state_q == jcbm_pkg::S_IDLE) begin
				widx_q <= '0;
			end else if (state_q == jcbm_pkg::S_ALLOC && mre) begin
				widx_q <= widx_q + WCW'(1);
			end
			if (state_q == jcbm_pkg::S_IDLE) begin
				tidx_q <= '0;
			end else if (tre) begin
				tidx_q <= tidx_q + CW'(1);
			end
			if (mfound) begin
				if (cmd_q == jcbm_pkg::CMD_CREATE) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					jtxn_q <= ntxn_q;
					ntxn_q <= ntxn_q + jcbm_pkg::TxnW'(1);
					jnew_q <= nb;
					jphase_q <= abort_q ? jcbm_pkg::PH_DATA_WRITTEN : jcbm_pkg::PH_COMMITTED;
				end
			end
			if (state_q == jcbm_pkg::S_REL_WR && cmd_q == jcbm_pkg::CMD_REPAIR) begin
				jphase_q <= jcbm_pkg::PH_EMPTY;
			end
			if (load) begin
				ovld_q <= 1'b1;
			end else if (rsp.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tidx_s1 <= tidx_q[TAW-1:0];
		widx_s1 <= widx_q[WAW-1:0];
		if (accept) begin
			cmd_q <= jcbm_pkg::cmd_t'(req.command);
			id_q <= req.file_id;
			len_q <= req.length;
			abort_q <= req.abort_before_commit;
			res_status_q <= jcbm_pkg::ST_OK;
			res_blk_q <= '0;
			res_len_q <= '0;
			case (jcbm_pkg::cmd_t'(req.command))
				jcbm_pkg::CMD_CREATE: begin
					if (cnt_q >= CW'(MAX_FILES)) res_status_q <= jcbm_pkg::ST_TABLE_FULL;
				end
				jcbm_pkg::CMD_REPAIR: begin
					if (repair_ok) begin
						res_blk_q <= jnew_q;
					end else begin
						res_status_q <= jcbm_pkg::ST_NOTHING;
					end
				end
				default: ;
			endcase
		end
		if (thit) begin
			slot_q <= tidx_s1;
			old_q <= t_blk;
			if (cmd_q == jcbm_pkg::CMD_READ) begin
				res_blk_q <= t_blk;
				res_len_q <= t_len;
			end
		end
		if (tmiss) res_status_q <= jcbm_pkg::ST_NOT_FOUND;
		if (mfound) res_blk_q <= nb;
		if (mmiss) res_status_q <= jcbm_pkg::ST_NO_BLOCK;
		if (load) begin
			ostatus_q <= res_status_q;
			oblk_q <= blk_x[jcbm_pkg::BlkOutW-1:0];
			olen_q <= res_len_q;
			ophase_q <= jphase_q;
			otxn_q <= jtxn_q;
		end
	end

	assign rsp.valid = ovld_q;
	assign rsp.status = ostatus_q;
	assign rsp.block_index = oblk_q;
	assign rsp.file_length = olen_q;
	assign rsp.journal_state = ophase_q;
	assign rsp.transaction_id = otxn_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_FILES))
		else $error("file table count beyond capacity");

	a_phase_set: assert property (@(posedge clk) disable iff (!arst_n)
		jphase_q == jcbm_pkg::PH_EMPTY || jphase_q == jcbm_pkg::PH_DATA_WRITTEN ||
		jphase_q == jcbm_pkg::PH_COMMITTED)
		else $error("journal in a phase that is never recorded");

	a_txn_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ntxn_q != $past(ntxn_q)) |-> (jtxn_q == $past(ntxn_q)))
		else $error("transaction counter advanced without a journal record");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovld_q) |-> ($past(state_q) == jcbm_pkg::S_DONE))
		else $error("response raised outside the finishing state");
`endif

endmodule

// ===== tb/journaled_cow_block_mapper_unit_tb.sv =====
// Self-checking testbench of the journaled copy-on-write block mapper.
// Predicts every response from its own model of the block map, file table and journal.
// Depends on jcbm_pkg, jcbm_ifs and journaled_cow_block_mapper_unit.
module journaled_cow_block_mapper_unit_tb;
	import jcbm_pkg::*;

	localparam int NBLK = 128;
	localparam int NFILE = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 120;
	localparam int LEAK_FLOOR = 24;

	typedef struct {
		status_t status;
		logic [BlkOutW-1:0] blk;
		logic [LenW-1:0] len;
		phase_t phase;
		logic [TxnW-1:0] txn;
	} mapper_resp_t;

	logic clk;
	logic arst_n;

	jcbm_req_if req_ch();
	jcbm_rsp_if rsp_ch();

	journaled_cow_block_mapper_unit #(
		.NUM_BLOCKS(NBLK),
		.MAX_FILES(NFILE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// predicted mapper state
	bit [NBLK-1:0] blk_used;
	logic [IdW-1:0] tbl_id[NFILE];
	logic [BlkOutW-1:0] tbl_blk[NFILE];
	logic [LenW-1:0] tbl_len[NFILE];
	int n_files;
	logic [TxnW-1:0] jr_txn;
	logic [BlkOutW-1:0] jr_new;
	phase_t jr_phase;
	logic [TxnW-1:0] next_txn;

	mapper_resp_t resp_q[$];
	mapper_resp_t resp_want;

	int src_idle_pct = 16;
	int snk_idle_pct = 63;
	int hold_asks = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int fail_count = 0;
	int cmds_sent = 0;
	int resp_seen = 0;
	int quiet = 0;
	int status_hits[5];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int lowest_free();
		for (int i = 0; i < NBLK; i++) begin
			if (!blk_used[i]) return i;
		end
		return -1;
	endfunction

	function automatic int find_file(logic [IdW-1:0] id);
		for (int i = 0; i < n_files; i++) begin
			if (tbl_id[i] == id) return i;
		end
		return -1;
	endfunction

	function automatic logic [IdW-1:0] known_id();
		if (n_files == 0) return IdW'($urandom_range(65535));
		return tbl_id[$urandom_range(n_files - 1)];
	endfunction

	function automatic logic [IdW-1:0] unknown_id();
		logic [IdW-1:0] id;
		id = IdW'($urandom_range(65535));
		while (find_file(id) >= 0) id = IdW'($urandom_range(65535));
		return id;
	endfunction

	function automatic mapper_resp_t map_step(cmd_t c, logic [IdW-1:0] id, logic [LenW-1:0] len,
		logic ab);
		mapper_resp_t r;
		int slot;
		int nb;
		logic [BlkOutW-1:0] old;
		r.status = ST_OK;
		r.blk = '0;
		r.len = '0;
		case (c)
			CMD_CREATE: begin
				nb = lowest_free();
				if (n_files >= NFILE) begin
					r.status = ST_TABLE_FULL;
				end else if (nb < 0) begin
					r.status = ST_NO_BLOCK;
				end else begin
					blk_used[nb] = 1'b1;
					tbl_id[n_files] = id;
					tbl_blk[n_files] = BlkOutW'(nb);
					tbl_len[n_files] = len;
					n_files++;
					r.blk = BlkOutW'(nb);
				end
			end
			CMD_WRITE: begin
				slot = find_file(id);
				nb = lowest_free();
				if (slot < 0) begin
					r.status = ST_NOT_FOUND;
				end else if (nb < 0) begin
					r.status = ST_NO_BLOCK;
				end else begin
					blk_used[nb] = 1'b1;
					jr_txn = next_txn;
					next_txn = next_txn + 1;
					jr_new = BlkOutW'(nb);
					jr_phase = PH_DATA_WRITTEN;
					if (!ab) begin
						old = tbl_blk[slot];
						tbl_blk[slot] = BlkOutW'(nb);
						tbl_len[slot] = len;
						jr_phase = PH_COMMITTED;
						blk_used[old] = 1'b0;
					end
					r.blk = BlkOutW'(nb);
				end
			end
			CMD_READ: begin
				slot = find_file(id);
				if (slot < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.blk = tbl_blk[slot];
					r.len = tbl_len[slot];
				end
			end
			default: begin
				if (jr_phase != PH_COMMITTED && jr_phase != PH_EMPTY) begin
					blk_used[jr_new] = 1'b0;
					r.blk = jr_new;
					jr_phase = PH_EMPTY;
				end else begin
					r.status = ST_NOTHING;
				end
			end
		endcase
		r.phase = jr_phase;
		r.txn = jr_txn;
		return r;
	endfunction

	task automatic report_fail(string msg);
		fail_count++;
		if (fail_count <= 10) $display("%s", msg);
	endtask

	task automatic send_cmd(cmd_t c, logic [IdW-1:0] id, logic [LenW-1:0] len, logic ab);
		mapper_resp_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= c;
		req_ch.file_id <= id;
		req_ch.length <= len;
		req_ch.abort_before_commit <= ab;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		r = map_step(c, id, len, ab);
		resp_q = {resp_q, r};
		status_hits[r.status]++;
		cmds_sent++;
	endtask

	task automatic test_basic_lifecycle();
		send_cmd(CMD_READ, 16'h0000, 8'd0, 1'b0);
		send_cmd(CMD_WRITE, 16'hFFFF, 8'd255, 1'b0);
		send_cmd(CMD_REPAIR, 16'h0000, 8'd0, 1'b1);
		send_cmd(CMD_CREATE, 16'h0000, 8'd0, 1'b0);
		send_cmd(CMD_CREATE, 16'hFFFF, 8'd255, 1'b1);
		send_cmd(CMD_CREATE, 16'h0000, 8'd77, 1'b0);
		send_cmd(CMD_READ, 16'h0000, 8'd255, 1'b1);
		send_cmd(CMD_READ, 16'hFFFF, 8'd0, 1'b0);
		send_cmd(CMD_WRITE, 16'h0000, 8'd200, 1'b0);
		send_cmd(CMD_READ, 16'h0000, 8'd0, 1'b0);
		send_cmd(CMD_REPAIR, 16'hFFFF, 8'd255, 1'b0);
		send_cmd(CMD_WRITE, 16'hFFFF, 8'd5, 1'b1);
		send_cmd(CMD_READ, 16'hFFFF, 8'd0, 1'b0);
		send_cmd(CMD_WRITE, 16'h0000, 8'd9, 1'b1);
		send_cmd(CMD_REPAIR, 16'h0000, 8'd0, 1'b0);
		send_cmd(CMD_REPAIR, 16'h0000, 8'd0, 1'b0);
		send_cmd(CMD_CREATE, 16'h8000, 8'd128, 1'b0);
		send_cmd(CMD_WRITE, 16'h1234, 8'd1, 1'b1);
		send_cmd(CMD_READ, 16'h8000, 8'd0, 1'b0);
		send_cmd(CMD_WRITE, 16'h8000, 8'd127, 1'b0);
		send_cmd(CMD_READ, 16'h8000, 8'd0, 1'b0);
	endtask

	task automatic test_random_traffic(int n, int src_pct, int snk_pct);
		int sent;
		int pick;
		cmd_t c;
		logic [IdW-1:0] id;
		logic ab;
		sent = 0;
		src_idle_pct <= src_pct;
		snk_idle_pct <= snk_pct;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (pick < 12 && n_files < NFILE - 1) begin
				id = ($urandom_range(3) == 0) ? known_id() : IdW'($urandom_range(65535));
				send_cmd(CMD_CREATE, id, LenW'($urandom_range(255)), 1'($urandom));
			end else if (pick < 35) begin
				id = ($urandom_range(6) == 0) ? unknown_id() : known_id();
				send_cmd(CMD_READ, id, LenW'($urandom_range(255)), 1'($urandom));
			end else if (pick < 60) begin
				send_cmd(CMD_WRITE, known_id(), LenW'($urandom_range(255)), 1'b0);
			end else if (pick < 80) begin
				// power loss after the data step, then recovery
				send_cmd(CMD_WRITE, known_id(), LenW'($urandom_range(255)), 1'b1);
				send_cmd(CMD_REPAIR, IdW'($urandom_range(65535)), LenW'($urandom_range(255)),
					1'($urandom));
				sent++;
			end else if (pick < 90) begin
				ab = (NBLK - $countones(blk_used)) > LEAK_FLOOR;
				send_cmd(CMD_WRITE, known_id(), LenW'($urandom_range(255)), ab);
			end else begin
				c = cmd_t'($urandom_range(3));
				id = IdW'($urandom_range(65535));
				ab = 1'($urandom);
				if (c == CMD_CREATE && n_files >= NFILE - 1) c = CMD_READ;
				if (c == CMD_WRITE && (NBLK - $countones(blk_used)) <= LEAK_FLOOR) ab = 1'b0;
				send_cmd(c, id, LenW'($urandom_range(255)), ab);
			end
			sent++;
		end
	endtask

	task automatic test_backpressure();
		src_idle_pct <= 0;
		snk_idle_pct <= 0;
		hold_asks <= hold_asks + 1;
		for (int i = 0; i < 8; i++) begin
			send_cmd(CMD_READ, known_id(), LenW'($urandom_range(255)), 1'b0);
		end
	endtask

	task automatic test_block_exhaustion();
		src_idle_pct <= 10;
		snk_idle_pct <= 30;
		while (n_files < NFILE - 1 && lowest_free() >= 0) begin
			send_cmd(CMD_CREATE, IdW'($urandom_range(65535)), LenW'($urandom_range(255)), 1'b0);
		end
		// leak every remaining block through overwritten uncommitted transactions
		while (lowest_free() >= 0) begin
			send_cmd(CMD_WRITE, known_id(), LenW'($urandom_range(255)), 1'b1);
		end
		send_cmd(CMD_CREATE, 16'h4242, 8'd3, 1'b0);
		send_cmd(CMD_WRITE, known_id(), 8'd4, 1'b0);
		send_cmd(CMD_WRITE, known_id(), 8'd5, 1'b1);
		send_cmd(CMD_WRITE, unknown_id(), 8'd6, 1'b0);
		send_cmd(CMD_READ, known_id(), 8'd0, 1'b0);
		send_cmd(CMD_REPAIR, 16'h0000, 8'd0, 1'b0);
		send_cmd(CMD_CREATE, 16'hFFFF, 8'd255, 1'b0);
		send_cmd(CMD_CREATE, 16'h0000, 8'd0, 1'b0);
		send_cmd(CMD_CREATE, 16'hFFFF, 8'd255, 1'b1);
		send_cmd(CMD_REPAIR, 16'hFFFF, 8'd255, 1'b1);
		send_cmd(CMD_WRITE, known_id(), 8'd7, 1'b0);
		send_cmd(CMD_READ, unknown_id(), 8'd0, 1'b0);
		send_cmd(CMD_READ, known_id(), 8'd0, 1'b0);
	endtask

	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (resp_q.size() == 0) begin
				report_fail($sformatf("unexpected response: status %0d block %0d length %0d",
					rsp_ch.status, rsp_ch.block_index, rsp_ch.file_length));
			end else begin
				resp_want = resp_q.pop_front();
				if (rsp_ch.status !== resp_want.status || rsp_ch.block_index !== resp_want.blk ||
					rsp_ch.file_length !== resp_want.len ||
					rsp_ch.journal_state !== resp_want.phase ||
					rsp_ch.transaction_id !== resp_want.txn) begin
					report_fail($sformatf({"response %0d mismatch: expected st %0d blk %0d len %0d ",
						"ph %0d txn %0d, got st %0d blk %0d len %0d ph %0d txn %0d"}, resp_seen,
						resp_want.status, resp_want.blk, resp_want.len, resp_want.phase,
						resp_want.txn, rsp_ch.status, rsp_ch.block_index, rsp_ch.file_length,
						rsp_ch.journal_state, rsp_ch.transaction_id));
				end
				resp_seen++;
			end
		end
		if (hold_asks != hold_taken) begin
			hold_taken <= hold_asks;
			hold_left <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d responses pending",
				quiet, resp_q.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_CREATE;
		req_ch.file_id = '0;
		req_ch.length = '0;
		req_ch.abort_before_commit = 1'b0;
		blk_used = '0;
		n_files = 0;
		jr_txn = '0;
		jr_new = '0;
		jr_phase = PH_EMPTY;
		next_txn = 1;
		foreach (status_hits[i]) status_hits[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_basic_lifecycle();
		test_random_traffic(280, 16, 63);
		test_backpressure();
		test_random_traffic(280, 63, 16);
		test_random_traffic(280, 0, 0);
		test_block_exhaustion();
		req_ch.valid <= 1'b0;

		while (resp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands, %0d responses checked, %0d files, %0d blocks in use",
			cmds_sent, resp_seen, n_files, $countones(blk_used));
		$display("ok %0d, no block %0d, not found %0d, table full %0d, nothing to repair %0d",
			status_hits[ST_OK], status_hits[ST_NO_BLOCK], status_hits[ST_NOT_FOUND],
			status_hits[ST_TABLE_FULL], status_hits[ST_NOTHING]);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/jcbm_pkg.sv
hw/rtl/jcbm_ifs.sv
hw/rtl/jcbm_ram.sv
hw/rtl/jcbm_find_free.sv
hw/rtl/journaled_cow_block_mapper_unit.sv
tb/journaled_cow_block_mapper_unit_tb.sv
